[hw/rtl/rfv_pkg.sv]
// Shared types and constants for the row frame validator.
// Used by every module of the block; depends on nothing.

package rfv_pkg;

	localparam int unsigned FRAME_MAX  = 8388608;
	localparam int unsigned ROW_MAX    = 4096;
	localparam int unsigned COL_MAX    = 256;

	localparam int unsigned POS_W      = $clog2(FRAME_MAX + 2);
	localparam int unsigned ROW_W      = $clog2(ROW_MAX + 1);
	localparam int unsigned COL_W      = 9;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned WORD_W     = 32;

	localparam logic [WORD_W-1:0] MAGIC         = 32'h3153_5242;
	localparam logic [BYTE_W-1:0] ERR_MARK      = 8'h45;
	localparam int unsigned       HDR_BYTES     = 12;
	localparam int unsigned       HDR_MAGIC_END = 3;
	localparam int unsigned       HDR_COLS_END  = 7;
	localparam int unsigned       HDR_ROWS_END  = 11;
	localparam int unsigned       FIXED_PAYLOAD = 8;

	localparam logic [BYTE_W-1:0] TAG_NULL = 8'd0;
	localparam logic [BYTE_W-1:0] TAG_INT  = 8'd1;
	localparam logic [BYTE_W-1:0] TAG_REAL = 8'd2;
	localparam logic [BYTE_W-1:0] TAG_TEXT = 8'd3;
	localparam logic [BYTE_W-1:0] TAG_BLOB = 8'd4;

	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] REG_COLUMN_COUNT = 3'd0;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_LONG   = 3'd1,
		ST_EFRAME = 3'd2,
		ST_HEADER = 3'd3,
		ST_CELL   = 3'd4,
		ST_TRAIL  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_TAG     = 2'd0,
		PH_LEN     = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// Packed so that status lands in the low bits of the output word.
	typedef struct packed {
		logic [ROW_W-1:0] row_count;
		status_t          status;
	} result_t;

endpackage

[hw/rtl/rfv_in_reg.sv]
// Input register stage: captures one byte word from the slave stream.
// Depends on rfv_pkg.

module rfv_in_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [rfv_pkg::BYTE_W-1:0] s_byte,
	input  logic                      s_tlast,
	input  logic                      advance,
	output logic                      valid_s1,
	output logic [rfv_pkg::BYTE_W-1:0] byte_s1,
	output logic                      last_s1
);

	logic take;

	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_byte;
			last_s1 <= s_tlast;
		end
	end

endmodule

[hw/rtl/rfv_frame_engine.sv]
// Frame state and per-byte checks: header, cell walk, length count, status.
// Depends on rfv_pkg.

module rfv_frame_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [rfv_pkg::BYTE_W-1:0] byte_value,
	input  logic                       last_byte,
	input  logic [rfv_pkg::COL_W-1:0]  col_cnt,
	output logic                       res_valid,
	output rfv_pkg::result_t           res
);

	localparam int unsigned POS_W  = rfv_pkg::POS_W;
	localparam int unsigned ROW_W  = rfv_pkg::ROW_W;
	localparam int unsigned COL_W  = rfv_pkg::COL_W;
	localparam int unsigned WORD_W = rfv_pkg::WORD_W;

	logic [POS_W-1:0]  pos_q, pos_n;
	logic [WORD_W-1:0] hdr_q, hdr_n;
	logic              first_e_q, first_e_n;
	logic [ROW_W-1:0]  rows_q, rows_n;
	logic [ROW_W-1:0]  row_idx_q, row_idx_n;
	logic [COL_W-1:0]  col_idx_q, col_idx_n;
	rfv_pkg::phase_t   phase_q, phase_n;
	logic [WORD_W-1:0] left_q, left_n;
	logic [1:0]        len_idx_q, len_idx_n;
	rfv_pkg::status_t  err_q, err_n;

	logic [WORD_W-1:0] hdr_sh;
	logic [WORD_W-1:0] left_len;
	logic [WORD_W-1:0] left_dec;
	logic [COL_W-1:0]  col_inc;
	logic              cells_done_q;
	logic              cells_done_n;
	logic              finish;

	always_comb begin
		pos_n        = pos_q;
		hdr_n        = hdr_q;
		first_e_n    = first_e_q;
		rows_n       = rows_q;
		row_idx_n    = row_idx_q;
		col_idx_n    = col_idx_q;
		phase_n      = phase_q;
		left_n       = left_q;
		len_idx_n    = len_idx_q;
		err_n        = err_q;
		finish       = 1'b0;
		hdr_sh       = {byte_value, hdr_q[WORD_W-1:rfv_pkg::BYTE_W]};
		left_len     = left_q | (WORD_W'(byte_value) << {len_idx_q, 3'b000});
		left_dec     = left_q - WORD_W'(1);
		col_inc      = col_idx_q + COL_W'(1);
		cells_done_q = (col_cnt == '0) || (row_idx_q >= rows_q);

		if (step) begin
			if (pos_q < POS_W'(rfv_pkg::FRAME_MAX)) begin
				if (pos_q == '0 && byte_value == rfv_pkg::ERR_MARK) begin
					first_e_n = 1'b1;
				end
				if (err_q == rfv_pkg::ST_OK) begin
					if (pos_q < POS_W'(rfv_pkg::HDR_BYTES)) begin
						hdr_n = hdr_sh;
						if (pos_q == POS_W'(rfv_pkg::HDR_MAGIC_END) &&
						    hdr_sh != rfv_pkg::MAGIC) begin
							err_n = rfv_pkg::ST_HEADER;
						end
						if (pos_q == POS_W'(rfv_pkg::HDR_COLS_END) &&
						    hdr_sh != WORD_W'(col_cnt)) begin
							err_n = rfv_pkg::ST_HEADER;
						end
						if (pos_q == POS_W'(rfv_pkg::HDR_ROWS_END)) begin
							if (hdr_sh > WORD_W'(rfv_pkg::ROW_MAX)) begin
								err_n = rfv_pkg::ST_HEADER;
							end else begin
								rows_n = hdr_sh[ROW_W-1:0];
							end
						end
					end else begin
						unique case (phase_q)
							rfv_pkg::PH_TAG: begin
								if (cells_done_q) begin
									err_n = rfv_pkg::ST_TRAIL;
								end else begin
									case (byte_value) inside
										rfv_pkg::TAG_NULL: begin
											finish = 1'b1;
										end
										rfv_pkg::TAG_INT, rfv_pkg::TAG_REAL: begin
											left_n  = WORD_W'(rfv_pkg::FIXED_PAYLOAD);
											phase_n = rfv_pkg::PH_PAYLOAD;
										end
										rfv_pkg::TAG_TEXT, rfv_pkg::TAG_BLOB: begin
											left_n    = '0;
											len_idx_n = '0;
											phase_n   = rfv_pkg::PH_LEN;
										end
										default: begin
											err_n = rfv_pkg::ST_CELL;
										end
									endcase
								end
							end
							rfv_pkg::PH_LEN: begin
								left_n = left_len;
								if (len_idx_q == 2'd3) begin
									len_idx_n = '0;
									if (left_len == '0) begin
										finish = 1'b1;
									end else begin
										phase_n = rfv_pkg::PH_PAYLOAD;
									end
								end else begin
									len_idx_n = len_idx_q + 2'd1;
								end
							end
							rfv_pkg::PH_PAYLOAD: begin
								left_n = left_dec;
								if (left_dec == '0) begin
									finish = 1'b1;
								end
							end
							default: begin
							end
						endcase
						// advance to the next cell, wrapping into the next row
						if (finish) begin
							phase_n = rfv_pkg::PH_TAG;
							if (col_inc >= col_cnt) begin
								col_idx_n = '0;
								row_idx_n = row_idx_q + ROW_W'(1);
							end else begin
								col_idx_n = col_inc;
							end
						end
					end
				end
			end
			// saturate one past the limit
			if (pos_q <= POS_W'(rfv_pkg::FRAME_MAX)) begin
				pos_n = pos_q + POS_W'(1);
			end
		end

		cells_done_n  = (col_cnt == '0) || (row_idx_n >= rows_n);
		res.row_count = '0;
		if (pos_n > POS_W'(rfv_pkg::FRAME_MAX)) begin
			res.status = rfv_pkg::ST_LONG;
		end else if (first_e_n) begin
			res.status = rfv_pkg::ST_EFRAME;
		end else if (err_n != rfv_pkg::ST_OK) begin
			res.status = err_n;
		end else if (pos_n < POS_W'(rfv_pkg::HDR_BYTES)) begin
			res.status = rfv_pkg::ST_HEADER;
		end else if (phase_n != rfv_pkg::PH_TAG || !cells_done_n) begin
			res.status = rfv_pkg::ST_CELL;
		end else begin
			res.status    = rfv_pkg::ST_OK;
			res.row_count = rows_n;
		end

		res_valid = step && last_byte;

		// drop all frame state after the final byte
		if (res_valid) begin
			pos_n     = '0;
			hdr_n     = '0;
			first_e_n = 1'b0;
			rows_n    = '0;
			row_idx_n = '0;
			col_idx_n = '0;
			phase_n   = rfv_pkg::PH_TAG;
			left_n    = '0;
			len_idx_n = '0;
			err_n     = rfv_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hdr_q     <= '0;
			first_e_q <= 1'b0;
			rows_q    <= '0;
			row_idx_q <= '0;
			col_idx_q <= '0;
			phase_q   <= rfv_pkg::PH_TAG;
			left_q    <= '0;
			len_idx_q <= '0;
			err_q     <= rfv_pkg::ST_OK;
		end else begin
			pos_q     <= pos_n;
			hdr_q     <= hdr_n;
			first_e_q <= first_e_n;
			rows_q    <= rows_n;
			row_idx_q <= row_idx_n;
			col_idx_q <= col_idx_n;
			phase_q   <= phase_n;
			left_q    <= left_n;
			len_idx_q <= len_idx_n;
			err_q     <= err_n;
		end
	end

endmodule

[hw/rtl/rfv_out_reg.sv]
// Result register: holds one status word until the master stream takes it.
// Depends on rfv_pkg.

module rfv_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rfv_pkg::result_t res,
	input  logic             m_tready,
	output logic             m_tvalid,
	output rfv_pkg::result_t m_res,
	output logic             free
);

	logic             valid_q;
	rfv_pkg::result_t res_q;

	assign m_tvalid = valid_q;
	assign m_res    = res_q;
	assign free     = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

[hw/rtl/row_frame_validator_core.sv]
// Top level of the row frame validator: stream ports, APB register, stages.
// Depends on rfv_pkg, rfv_in_reg, rfv_frame_engine, rfv_out_reg.

// The block takes one frame byte per word on the slave stream, with tlast on
// the final byte, and sustains one byte per clock unless a final byte is held
// for an unread status word. Each byte passes an input register, then the
// counter and compare updates that also form the status, which is loaded into
// the result register as the final byte leaves the input register; the slave
// side keeps taking bytes while that word waits on the master side, until the
// next final byte reaches the input register. Exactly one status word (status,
// row_count) comes out per frame. The user must write column_count over APB at
// address 0 only while no frame is in progress; the block does not enforce it.

module row_frame_validator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rfv_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// slave stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] byte_value
	input  logic                        s_tlast,  // last_byte
	// master stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata   // [2:0] status, [15:3] row_count
);

	logic [rfv_pkg::COL_W-1:0]  col_cnt_q;
	logic                       valid_s1;
	logic [rfv_pkg::BYTE_W-1:0] byte_s1;
	logic                       last_s1;
	logic                       advance;
	logic                       out_free;
	logic                       res_valid;
	rfv_pkg::result_t           res;
	rfv_pkg::result_t           m_res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= rfv_pkg::COL_W'(1);
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == rfv_pkg::REG_COLUMN_COUNT[2]) begin
			col_cnt_q <= pwdata[rfv_pkg::COL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == rfv_pkg::REG_COLUMN_COUNT[2]) begin
			prdata = 32'(col_cnt_q);
		end
	end

	// hold a final byte while the previous status word is still unread
	assign advance = valid_s1 && (!last_s1 || out_free);

	rfv_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_byte   (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	rfv_frame_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.col_cnt    (col_cnt_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	rfv_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_res    (m_res),
		.free     (out_free)
	);

	assign m_tdata = m_res;

endmodule

[hw/rtl/rfv_checker.sv]
// Port-level checks for row_frame_validator_core, bound to the top level.
// Depends on rfv_pkg.

module rfv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// hold a stalled status word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("status word changed while stalled");

	// with the result register empty nothing can block the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !m_tvalid |-> s_tready)
		else $error("input stalled with no status word waiting");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'(rfv_pkg::ST_TRAIL))
		else $error("status code out of range");

	a_rows_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != 3'(rfv_pkg::ST_OK) |-> m_tdata[15:3] == '0)
		else $error("row count set on failing frame");

	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == 3'(rfv_pkg::ST_OK) |->
			m_tdata[15:3] <= 13'(rfv_pkg::ROW_MAX))
		else $error("row count above limit");

endmodule

bind row_frame_validator_core rfv_checker u_rfv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
